@@ design/lrs_pkg.sv @@
`default_nettype none

package lrs_pkg;

    localparam int ROW_W        = 64;
    localparam int IDX_W        = 6;
    localparam int MASK_W       = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int DEF_WIDTH    = 64;
    localparam int DEF_MAX_ROWS = 64;

    // result queue, power of two, at least 4
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = CFG_IDX_W'(1);

    // b3/s23
    localparam logic [MASK_W-1:0] BIRTH_RESET   = MASK_W'(8);
    localparam logic [MASK_W-1:0] SURVIVE_RESET = MASK_W'(12);

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] next_row;
        logic             gen_done;
        logic             frame_error;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    e0;
        t_result    e1;
        t_result    e2;
    } t_q_push;

endpackage

`default_nettype wire

@@ design/lrs_evolve.sv @@
`default_nettype none

module lrs_evolve
    import lrs_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  wire logic [WIDTH-1:0]  i_up,
    input  wire logic [WIDTH-1:0]  i_mid,
    input  wire logic [WIDTH-1:0]  i_down,
    input  wire logic [MASK_W-1:0] i_birth,
    input  wire logic [MASK_W-1:0] i_survive,
    output logic      [WIDTH-1:0]  o_next
);

    // one cell core per column
    for (genvar x = 0; x < WIDTH; x++) begin : g_cell
        localparam int XL = (x + WIDTH - 1) % WIDTH;
        localparam int XR = (x + 1) % WIDTH;

        logic [7:0] nb;
        logic [3:0] cnt;

        assign nb = {i_up[XL], i_up[x], i_up[XR], i_mid[XL], i_mid[XR],
                     i_down[XL], i_down[x], i_down[XR]};

        always_comb begin
            cnt = 4'd0;
            for (int k = 0; k < 8; k++) begin
                cnt = cnt + 4'(nb[k]);
            end
        end

        assign o_next[x] = i_mid[x] ? i_survive[cnt] : i_birth[cnt];
    end

endmodule

`default_nettype wire

@@ design/lrs_outq.sv @@
`default_nettype none

module lrs_outq
    import lrs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_push i_push,
    input  wire logic    i_pop_stall,
    output logic         o_valid,
    output t_result      o_head,
    output logic         o_nearly_full
);

    t_result r_mem [Q_DEPTH];

    logic [Q_PTR_W-1:0] r_head, n_head;
    logic [Q_PTR_W-1:0] r_tail, n_tail;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               pop;

    assign o_valid       = (r_cnt != '0);
    assign o_head        = r_mem[r_head];
    // room for a full burst of three results
    assign o_nearly_full = (r_cnt > Q_CNT_W'(Q_DEPTH - 3));
    assign pop           = o_valid && !i_pop_stall;

    always_comb begin
        n_head = r_head + Q_PTR_W'(pop);
        n_tail = r_tail + Q_PTR_W'(i_push.n);
        n_cnt  = r_cnt + Q_CNT_W'(i_push.n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    // pack the burst into consecutive slots
    always_ff @(posedge i_clk) begin
        if (i_push.n >= 2'd1) begin
            r_mem[r_tail] <= i_push.e0;
        end
        if (i_push.n >= 2'd2) begin
            r_mem[r_tail + Q_PTR_W'(1)] <= i_push.e1;
        end
        if (i_push.n == 2'd3) begin
            r_mem[r_tail + Q_PTR_W'(2)] <= i_push.e2;
        end
    end

endmodule

`default_nettype wire

@@ design/life_like_automaton_row_step.sv @@
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_row_bits, i_last_row
// result    out        o_out_valid / i_out_stall    o_row_index, o_next_row,
//                                                   o_gen_done, o_frame_error
// config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// one row per cycle while o_in_stall is low; a row's results enter the result
// queue at the edge that accepts it and leave it in order as the output takes them
// the last row of a well-formed generation gives three results, popped one by
// one; the four-entry queue throttles the input while it holds >1
// synchronous active-low reset clears counters, flags, queue; rule masks to b3/s23
// a stalled output keeps its item, the input keeps flowing until the queue holds >1
`default_nettype none

module life_like_automaton_row_step
    import lrs_pkg::*;
#(
    parameter int WIDTH    = DEF_WIDTH,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [ROW_W-1:0]     i_row_bits,
    input  wire logic                 i_last_row,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [IDX_W-1:0]     o_row_index,
    output logic      [ROW_W-1:0]     o_next_row,
    output logic                      o_gen_done,
    output logic                      o_frame_error,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [MASK_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_ROWS + 1);   // r_rows, saturates at MAX_ROWS
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    // rule masks
    logic [MASK_W-1:0] r_birth;
    logic [MASK_W-1:0] r_survive;

    // row window
    logic [WIDTH-1:0] r_first, r_second, r_older, r_newer;
    logic [CW-1:0]    r_rows, n_rows;
    logic             r_ovf, n_ovf;

    logic             accept;
    logic [WIDTH-1:0] cur;
    logic             ovf_now;
    logic             err_res;
    logic             drop;
    logic [IW-1:0]    r_ext;
    logic [IW-1:0]    r_prev;
    logic [WIDTH-1:0] nxt_a, nxt_b, nxt_c;
    t_q_push          push;
    t_result          head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= BIRTH_RESET;
            r_survive <= SURVIVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIRTH:   r_birth   <= i_cfg_data;
                CFG_SURVIVE: r_survive <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    assign accept = i_in_valid && !o_in_stall;
    assign cur    = i_row_bits[WIDTH-1:0];

    // a row beyond MAX_ROWS flags the frame from that row on
    assign ovf_now = r_ovf || (r_rows >= CW'(MAX_ROWS));
    assign err_res = i_last_row && (ovf_now || (r_rows < CW'(2)));
    assign drop    = ovf_now && !i_last_row;

    assign r_ext  = IW'(r_rows);
    assign r_prev = r_ext - IW'(1);

    // three lanes: row before the current one, current row, row 0
    lrs_evolve #(.WIDTH(WIDTH)) u_lane_a (
        .i_up     (r_older),
        .i_mid    (r_newer),
        .i_down   (cur),
        .i_birth  (r_birth),
        .i_survive(r_survive),
        .o_next   (nxt_a)
    );

    lrs_evolve #(.WIDTH(WIDTH)) u_lane_b (
        .i_up     (r_newer),
        .i_mid    (cur),
        .i_down   (r_first),
        .i_birth  (r_birth),
        .i_survive(r_survive),
        .o_next   (nxt_b)
    );

    lrs_evolve #(.WIDTH(WIDTH)) u_lane_c (
        .i_up     (cur),
        .i_mid    (r_first),
        .i_down   (r_second),
        .i_birth  (r_birth),
        .i_survive(r_survive),
        .o_next   (nxt_c)
    );

    // merge: the error result stands alone, otherwise lane a leads and a
    // last row appends lanes b and c
    always_comb begin
        push.e0.row_index   = r_prev[IDX_W-1:0];
        push.e0.next_row    = ROW_W'(nxt_a);
        push.e0.gen_done    = 1'b0;
        push.e0.frame_error = 1'b0;
        push.e1.row_index   = r_ext[IDX_W-1:0];
        push.e1.next_row    = ROW_W'(nxt_b);
        push.e1.gen_done    = 1'b0;
        push.e1.frame_error = 1'b0;
        push.e2.row_index   = '0;
        push.e2.next_row    = ROW_W'(nxt_c);
        push.e2.gen_done    = 1'b1;
        push.e2.frame_error = 1'b0;
        push.n              = 2'd0;

        if (accept) begin
            if (err_res) begin
                push.e0.row_index   = '0;
                push.e0.next_row    = '0;
                push.e0.gen_done    = 1'b1;
                push.e0.frame_error = 1'b1;
                push.n              = 2'd1;
            end else if (!drop) begin
                // here r_rows >= 2 whenever the row is last
                if (i_last_row) begin
                    push.n = 2'd3;
                end else if (r_rows >= CW'(2)) begin
                    push.n = 2'd1;
                end
            end
        end
    end

    always_comb begin
        n_rows = r_rows;
        n_ovf  = r_ovf;
        if (accept) begin
            if (i_last_row) begin
                n_rows = '0;
                n_ovf  = 1'b0;
            end else if (ovf_now) begin
                n_ovf = 1'b1;
            end else begin
                n_rows = r_rows + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_rows <= n_rows;
            r_ovf  <= n_ovf;
        end
    end

    // window shifts on every row that is neither dropped nor an error
    always_ff @(posedge i_clk) begin
        if (accept && !err_res && !drop) begin
            r_older <= r_newer;
            r_newer <= cur;
            if (!i_last_row && r_rows == CW'(0)) begin
                r_first <= cur;
            end
            if (!i_last_row && r_rows == CW'(1)) begin
                r_second <= cur;
            end
        end
    end

    lrs_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop_stall  (i_out_stall),
        .o_valid      (o_out_valid),
        .o_head       (head),
        .o_nearly_full(o_in_stall)
    );

    assign o_row_index   = head.row_index;
    assign o_next_row    = head.next_row;
    assign o_gen_done    = head.gen_done;
    assign o_frame_error = head.frame_error;

endmodule

`default_nettype wire

@@ design/lrs_checker.sv @@
`default_nettype none

module lrs_checker
    import lrs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic [ROW_W-1:0]     i_row_bits,
    input wire logic                 i_last_row,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [IDX_W-1:0]     o_row_index,
    input wire logic [ROW_W-1:0]     o_next_row,
    input wire logic                 o_gen_done,
    input wire logic                 o_frame_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_next_row)
            && $stable(o_row_index) && $stable(o_gen_done))
        else $error("stalled result changed");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_row_bits)
            && $stable(i_last_row))
        else $error("stalled input item changed");

    // an error result is the lone closing item of its generation
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_error |-> o_gen_done && o_row_index == '0
            && o_next_row == '0)
        else $error("malformed error item");

    // an empty queue never holds off the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no result pending");

endmodule

bind life_like_automaton_row_step lrs_checker u_lrs_checker (.*);

`default_nettype wire

@@ sim/life_row_checker.sv @@
module life_row_checker
    import lrs_pkg::*;
#(
    parameter int WIDTH    = DEF_WIDTH,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [ROW_W-1:0]     i_row_bits,
    input  logic                 i_last_row,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [IDX_W-1:0]     i_row_index,
    input  logic [ROW_W-1:0]     i_next_row,
    input  logic                 i_gen_done,
    input  logic                 i_frame_error,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MASK_W-1:0]    i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam logic [ROW_W-1:0] ROW_MASK =
        (WIDTH >= ROW_W) ? '1 : ((ROW_W'(1) << WIDTH) - ROW_W'(1));
    localparam int REPORT_LIMIT = 40;

    // rule masks and the row window as the block should hold them
    logic [MASK_W-1:0] birth_rule;
    logic [MASK_W-1:0] survive_rule;
    logic [ROW_W-1:0]  top_row;
    logic [ROW_W-1:0]  top_row_next;
    logic [ROW_W-1:0]  prev2_row;
    logic [ROW_W-1:0]  prev1_row;
    int                rows_held;
    bit                too_many;

    t_result expected_rows[$];
    int      mismatches = 0;

    // next state of mid with wrap on both sides
    function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] up,
                                                    input logic [ROW_W-1:0] mid,
                                                    input logic [ROW_W-1:0] down);
        logic [ROW_W-1:0] nxt;
        int x;
        int xl;
        int xr;
        int n;
        nxt = '0;
        for (x = 0; x < WIDTH; x++) begin
            xl = (x + WIDTH - 1) % WIDTH;
            xr = (x + 1) % WIDTH;
            n = int'(up[xl]) + int'(up[x]) + int'(up[xr]) + int'(mid[xl]) + int'(mid[xr])
              + int'(down[xl]) + int'(down[x]) + int'(down[xr]);
            nxt[x] = mid[x] ? survive_rule[n] : birth_rule[n];
        end
        return nxt & ROW_MASK;
    endfunction

    function automatic void queue_result(input int idx, input logic [ROW_W-1:0] row,
                                         input logic done, input logic err);
        t_result res;
        res.row_index   = IDX_W'(idx);
        res.next_row    = row & ROW_MASK;
        res.gen_done    = done;
        res.frame_error = err;
        expected_rows.push_back(res);
    endfunction

    function automatic void predict_row_results(input logic [ROW_W-1:0] bits,
                                                input logic last);
        logic [ROW_W-1:0] cur;
        int r;
        cur = bits & ROW_MASK;
        r = rows_held;
        if (r >= MAX_ROWS)
            too_many = 1'b1;
        if (last && (too_many || r < 2)) begin
            // malformed generation: one error result
            queue_result(0, '0, 1'b1, 1'b1);
            rows_held = 0;
            too_many  = 1'b0;
        end else if (!too_many) begin
            if (r >= 2)
                queue_result(r - 1, evolve_row(prev2_row, prev1_row, cur), 1'b0, 1'b0);
            if (last) begin
                queue_result(r, evolve_row(prev1_row, cur, top_row), 1'b0, 1'b0);
                queue_result(0, evolve_row(cur, top_row, top_row_next), 1'b1, 1'b0);
                rows_held = 0;
            end else begin
                if (r == 0)
                    top_row = cur;
                else if (r == 1)
                    top_row_next = cur;
                rows_held = r + 1;
            end
            prev2_row = prev1_row;
            prev1_row = cur;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [ROW_W-1:0] want,
                                          input logic [ROW_W-1:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_LIMIT)
                $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (expected_rows.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
                $error("unexpected result: row_index %0d next_row %h", i_row_index, i_next_row);
            mismatches++;
        end else begin
            want = expected_rows.pop_front();
            compare_field("row_index", ROW_W'(want.row_index), ROW_W'(i_row_index));
            compare_field("next_row", want.next_row, i_next_row);
            compare_field("gen_done", ROW_W'(want.gen_done), ROW_W'(i_gen_done));
            compare_field("frame_error", ROW_W'(want.frame_error), ROW_W'(i_frame_error));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            birth_rule   = BIRTH_RESET;
            survive_rule = SURVIVE_RESET;
            top_row      = '0;
            top_row_next = '0;
            prev2_row    = '0;
            prev1_row    = '0;
            rows_held    = 0;
            too_many     = 1'b0;
            expected_rows.delete();
        end else begin
            // results of a row show only after the edge that accepts it, so compare before predicting
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIRTH:   birth_rule = i_cfg_data;
                    CFG_SURVIVE: survive_rule = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_row_results(i_row_bits, i_last_row);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_rows.size();
    end

endmodule

@@ sim/tb.sv @@
module tb;
    import lrs_pkg::*;

    localparam int  CLK_PERIOD       = 10;
    localparam int  RESET_CYCLES     = 8;
    localparam int  SETTLE_CYCLES    = 4;
    localparam int  LONG_HOLD_CYCLES = 120;
    localparam int  CYCLE_LIMIT      = 400000;

    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [ROW_W-1:0]     i_row_bits  = '0;
    logic                 i_last_row  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [IDX_W-1:0]     o_row_index;
    logic [ROW_W-1:0]     o_next_row;
    logic                 o_gen_done;
    logic                 o_frame_error;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_BIRTH;
    logic [MASK_W-1:0]    i_cfg_data  = '0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int rows_sent   = 0;

    // idling knobs, changed per phase
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    // long hold-offs asked for by the stimulus and served by the receiver
    int hold_asks      = 0;
    int holds_done     = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    life_like_automaton_row_step uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_row_bits    (i_row_bits),
        .i_last_row    (i_last_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_index   (o_row_index),
        .o_next_row    (o_next_row),
        .o_gen_done    (o_gen_done),
        .o_frame_error (o_frame_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    life_row_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_row_bits    (i_row_bits),
        .i_last_row    (i_last_row),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_row_index   (o_row_index),
        .i_next_row    (o_next_row),
        .i_gen_done    (o_gen_done),
        .i_frame_error (o_frame_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // watchdog: a run that hangs is a failing run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // idle stretch length: mostly short, now and then long
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // row contents with varying density so rules see every neighbour count
    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return a & b;
            4:       return a | b;
            5:       return a & b & {$urandom, $urandom};
            default: return a;
        endcase
    endfunction

    // mostly well-formed boards, some too short, some near or past the row limit
    function automatic int pick_gen_rows();
        int k;
        k = $urandom_range(0, 99);
        if (k < 6)
            return $urandom_range(1, 2);
        if (k < 9)
            return $urandom_range(DEF_MAX_ROWS - 2, DEF_MAX_ROWS + 3);
        return $urandom_range(3, 10);
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_row(input logic [ROW_W-1:0] bits, input logic last);
        int gap;
        i_in_valid <= 1'b1;
        i_row_bits <= bits;
        i_last_row <= last;
        do
            @(posedge i_clk);
        while (o_in_stall);
        rows_sent++;
        gap = (sender_idles && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
        if (gap > 0) begin
            // valid stays high across back-to-back items, dropped only for a gap
            i_in_valid <= 1'b0;
            i_row_bits <= random_row();
            i_last_row <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_generation(input int rows);
        int r;
        for (r = 0; r < rows; r++)
            send_row(random_row(), r == rows - 1);
    endtask

    task automatic run_phase(input int budget);
        int start;
        start = rows_sent;
        while (rows_sent - start < budget)
            run_generation(pick_gen_rows());
    endtask

    // stop offering and let every predicted result come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_rules(input logic [MASK_W-1:0] birth, input logic [MASK_W-1:0] survive);
        write_reg(CFG_BIRTH, birth);
        write_reg(CFG_SURVIVE, survive);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_asks) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!receiver_idles || $urandom_range(0, 99) < 70) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                repeat (pick_idle_len()) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int p;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset rule (b3/s23)
        // blinker straddling the column wrap
        send_row(64'h0, 1'b0);
        send_row(64'h8000_0000_0000_0003, 1'b0);
        send_row(64'h0, 1'b1);
        // field extremes and checkerboards
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        // board of one row: too few rows
        send_row(64'hDEAD_BEEF_0123_4567, 1'b1);
        // board of two rows: still too few
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        // smallest legal board, fully alive
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // glider near column 0, vertical wrap through the last row
        send_row(64'h2, 1'b0);
        send_row(64'h4, 1'b0);
        send_row(64'h7, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b1);
        wait_drained();

        // nothing is born, nothing survives; writes to spare indexes change nothing
        set_rules('0, '0);
        write_reg(CFG_SPARE_LO, MASK_W'($urandom));
        write_reg(CFG_SPARE_HI, '1);
        run_phase(25);
        wait_drained();

        // everything is born and survives, sender never idles
        set_rules('1, '1);
        sender_idles = 1'b0;
        run_phase(25);
        wait_drained();

        // back to b3/s23; long receiver hold-off while rows keep coming
        set_rules(BIRTH_RESET, SURVIVE_RESET);
        hold_asks++;
        run_generation(12);
        sender_idles = 1'b1;
        // tallest legal board, then one row too many on the last row
        run_generation(DEF_MAX_ROWS);
        run_generation(DEF_MAX_ROWS + 1);
        // sender waits for every result before going on
        wait_drained();
        run_phase(20);
        wait_drained();

        // random rules and idling mixes
        for (p = 0; p < 3; p++) begin
            set_rules(MASK_W'($urandom), MASK_W'($urandom));
            sender_idles   = 1'($urandom_range(0, 1));
            receiver_idles = 1'($urandom_range(0, 1));
            run_phase(20);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
